[rtl/vnu_pkg.sv]
// Types and constants shared by the vector normalise unit.
// No dependencies; every other rtl file uses this package.
`default_nettype none
package vnu_pkg;

  localparam int unsigned CompW  = 32;
  localparam int unsigned EpsW   = 16;
  localparam int unsigned SumW   = 64;
  localparam int unsigned RootW  = 32;
  localparam int unsigned RemW   = 34;
  localparam int unsigned QuotW  = 17;
  localparam int unsigned FracW  = 16;
  localparam int unsigned NLanes = 3;
  localparam logic [EpsW-1:0] EpsReset = 16'd7;

  typedef struct packed {
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
    logic                    is_three_d;
  } vnu_in_t;

  typedef struct packed {
    logic signed [CompW-1:0] unit_x;
    logic signed [CompW-1:0] unit_y;
    logic signed [CompW-1:0] unit_z;
    logic [CompW-1:0]        length;
    logic                    degenerate;
  } vnu_out_t;

  function automatic logic [CompW-1:0] vnu_mag(input logic [CompW-1:0] v);
    return v[CompW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

[rtl/vector_normalize_unit.sv]
// Top level of the vector normalise unit and the epsilon register.
// Depends on vnu_pkg, vnu_sumsq, vnu_isqrt and vnu_scale.
//
// Normalises a 2D or 3D signed Q16.16 vector and reports its Q16.16 length.
// Fully pipelined: one item per cycle while nothing stalls, through squaring
// and sum, the bit-per-stage square root, a prep stage, the per-lane
// restoring dividers and an output register. The whole pipeline
// halts while an output item waits under stall_i; stall_o follows that.
// Lengths below epsilon (or zero) give the input back with degenerate set.
`default_nettype none
module vector_normalize_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire vnu_pkg::vnu_in_t   in_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output vnu_pkg::vnu_out_t       out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [vnu_pkg::EpsW-1:0] cfg_wdata_i
);
  import vnu_pkg::*;

  logic [EpsW-1:0]  eps_q;
  logic             en;
  logic             sq_v, rt_v, degen;
  vnu_in_t          sq_it, rt_it;
  logic [SumW-1:0]  sum;
  logic [RootW-1:0] root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  vnu_sumsq u_sumsq (
    .clk_i, .rst_ni, .en_i(en), .valid_i, .item_i(in_i),
    .valid_o(sq_v), .item_o(sq_it), .sum_o(sum)
  );

  vnu_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v), .item_i(sq_it), .sum_i(sum),
    .valid_o(rt_v), .item_o(rt_it), .root_o(root)
  );

  assign degen = (root == '0) || (root < RootW'(eps_q));

  vnu_scale u_scale (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rt_v), .item_i(rt_it),
    .len_i(root), .degen_i(degen), .valid_o, .item_o(out_o)
  );
endmodule
`default_nettype wire

[rtl/vnu_sumsq.sv]
// Sum of squares: magnitude and square in one stage, sum in the next.
// Depends on vnu_pkg.
`default_nettype none
module vnu_sumsq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire vnu_pkg::vnu_in_t item_i,
  output logic                 valid_o,
  output vnu_pkg::vnu_in_t     item_o,
  output logic [vnu_pkg::SumW-1:0] sum_o
);
  import vnu_pkg::*;

  logic [SumW-1:0] sqx_q, sqy_q, sqz_q;
  logic            v1_q, v2_q;
  vnu_in_t         it1_q, it2_q;
  logic [SumW-1:0] sum_q;
  logic [CompW-1:0] mx, my, mz;

  assign mx = vnu_mag(item_i.comp_x);
  assign my = vnu_mag(item_i.comp_y);
  assign mz = vnu_mag(item_i.comp_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= SumW'(mx) * SumW'(mx);
      sqy_q <= SumW'(my) * SumW'(my);
      sqz_q <= item_i.is_three_d ? SumW'(mz) * SumW'(mz) : '0;
      it1_q <= item_i;
      sum_q <= sqx_q + sqy_q + sqz_q;
      it2_q <= it1_q;
    end
  end

  assign valid_o = v2_q;
  assign item_o  = it2_q;
  assign sum_o   = sum_q;
endmodule
`default_nettype wire

[rtl/vnu_isqrt.sv]
// Integer square root, one result bit per pipeline stage (32 stages).
// Depends on vnu_pkg.
`default_nettype none
module vnu_isqrt (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire vnu_pkg::vnu_in_t item_i,
  input  wire logic [vnu_pkg::SumW-1:0] sum_i,
  output logic                 valid_o,
  output vnu_pkg::vnu_in_t     item_o,
  output logic [vnu_pkg::RootW-1:0] root_o
);
  import vnu_pkg::*;

  logic [SumW-1:0]  s_q    [0:RootW];
  logic [RemW-1:0]  rem_q  [0:RootW];
  logic [RootW-1:0] root_q [0:RootW];
  logic             v_q    [0:RootW];
  vnu_in_t          it_q   [0:RootW];

  assign s_q[0]    = sum_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign v_q[0]    = valid_i;
  assign it_q[0]   = item_i;

  for (genvar gi = 0; gi < RootW; gi++) begin : g_stage
    logic [RemW+1:0] shifted, trial, diff;
    logic            ge;
    assign shifted = {rem_q[gi], s_q[gi][SumW-1 -: 2]};
    assign trial   = {2'b00, root_q[gi], 2'b01};
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi+1] <= 1'b0;
      end else if (en_i) begin
        v_q[gi+1] <= v_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[gi+1]    <= {s_q[gi][SumW-3:0], 2'b00};
        rem_q[gi+1]  <= ge ? diff[RemW-1:0] : shifted[RemW-1:0];
        root_q[gi+1] <= {root_q[gi][RootW-2:0], ge};
        it_q[gi+1]   <= it_q[gi];
      end
    end
  end

  assign valid_o = v_q[RootW];
  assign item_o  = it_q[RootW];
  assign root_o  = root_q[RootW];
endmodule
`default_nettype wire

[rtl/vnu_scale.sv]
// Scales each component by 1/length: magnitude stage, 17 restoring divide
// stages in three lanes, then sign and degenerate select. Depends on vnu_pkg.
`default_nettype none
module vnu_scale (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire vnu_pkg::vnu_in_t item_i,
  input  wire logic [vnu_pkg::RootW-1:0] len_i,
  input  wire logic            degen_i,
  output logic                 valid_o,
  output vnu_pkg::vnu_out_t    item_o
);
  import vnu_pkg::*;

  logic [CompW-1:0] rem_q [0:QuotW][0:NLanes-1];
  logic [QuotW-1:0] dv_q  [0:QuotW][0:NLanes-1];
  logic [QuotW-1:0] q_q   [0:QuotW][0:NLanes-1];
  logic [CompW-1:0] len_q [0:QuotW];
  logic             dg_q  [0:QuotW];
  logic             v_q   [0:QuotW];
  vnu_in_t          it_q  [0:QuotW];
  logic             vo_q;
  vnu_out_t         out_q;
  logic [CompW-1:0] comp_in [0:NLanes-1];
  logic [CompW-1:0] res [0:NLanes-1];

  assign comp_in[0] = item_i.comp_x;
  assign comp_in[1] = item_i.comp_y;
  assign comp_in[2] = item_i.comp_z;

  // prep stage: magnitudes into the divider seeds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
      vo_q   <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      vo_q   <= v_q[QuotW];
    end
  end

  for (genvar li = 0; li < NLanes; li++) begin : g_seed
    logic [CompW-1:0] m;
    assign m = vnu_mag(comp_in[li]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][li] <= {1'b0, m[CompW-1:1]};
        dv_q[0][li]  <= {m[0], {FracW{1'b0}}};
        q_q[0][li]   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q[0] <= len_i;
      dg_q[0]  <= degen_i;
      it_q[0]  <= item_i;
    end
  end

  for (genvar gj = 0; gj < QuotW; gj++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gj+1] <= 1'b0;
      end else if (en_i) begin
        v_q[gj+1] <= v_q[gj];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[gj+1] <= len_q[gj];
        dg_q[gj+1]  <= dg_q[gj];
        it_q[gj+1]  <= it_q[gj];
      end
    end

    for (genvar li = 0; li < NLanes; li++) begin : g_lane
      logic [CompW:0] sh, diff;
      logic           ge;
      assign sh   = {rem_q[gj][li], dv_q[gj][li][QuotW-1]};
      assign ge   = sh >= {1'b0, len_q[gj]};
      assign diff = sh - {1'b0, len_q[gj]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[gj+1][li] <= ge ? diff[CompW-1:0] : sh[CompW-1:0];
          dv_q[gj+1][li]  <= {dv_q[gj][li][QuotW-2:0], 1'b0};
          q_q[gj+1][li]   <= {q_q[gj][li][QuotW-2:0], ge};
        end
      end
    end
  end

  vnu_in_t it_l;
  assign it_l = it_q[QuotW];

  for (genvar li = 0; li < NLanes; li++) begin : g_sign
    logic [CompW-1:0] qx;
    logic             neg;
    assign qx  = CompW'(q_q[QuotW][li]);
    assign neg = (li == 0) ? it_l.comp_x[CompW-1] :
                 (li == 1) ? it_l.comp_y[CompW-1] : it_l.comp_z[CompW-1];
    assign res[li] = neg ? (~qx + 1'b1) : qx;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (dg_q[QuotW]) begin
        out_q.unit_x     <= it_l.comp_x;
        out_q.unit_y     <= it_l.comp_y;
        out_q.unit_z     <= it_l.comp_z;
        out_q.length     <= '0;
        out_q.degenerate <= 1'b1;
      end else begin
        out_q.unit_x     <= res[0];
        out_q.unit_y     <= res[1];
        out_q.unit_z     <= it_l.is_three_d ? res[2] : it_l.comp_z;
        out_q.length     <= len_q[QuotW];
        out_q.degenerate <= 1'b0;
      end
    end
  end

  assign valid_o = vo_q;
  assign item_o  = out_q;
endmodule
`default_nettype wire

[rtl/vnu_checker.sv]
// Port-level checks for the vector normalise unit, bound to the top level.
// Depends on vnu_pkg and vector_normalize_unit.
`default_nettype none
module vnu_port_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             stall_o,
  input wire logic             valid_o,
  input wire logic             stall_i,
  input wire vnu_pkg::vnu_out_t out_o
);
  // input side only backs up when an output item is held
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("stall_o without held item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(out_o))) else $error("held item changed");

  a_degen_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_o.degenerate) |-> (out_o.length == '0)) else $error("degenerate length");

  a_len_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_o.degenerate) |-> (out_o.length != '0)) else $error("zero length");
endmodule

bind vector_normalize_unit vnu_port_checker u_vnu_port_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .stall_o(stall_o), .valid_o(valid_o),
  .stall_i(stall_i), .out_o(out_o)
);
`default_nettype wire
